// ===== src/pal_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pal_pkg: shared types and constants of the positional array list
// Op and status codes, widths of the entry store, and the command beat that
// the controller hands to the row of entry cells.
// ----------------------------------------------------------------------------
package pal_pkg;

  localparam int DEPTH   = 64;
  localparam int IDX_W   = $clog2(DEPTH);
  localparam int CNT_W   = 7;
  localparam int DATA_W  = 32;
  localparam int OP_W    = 3;
  localparam int ST_W    = 2;

  typedef enum logic [OP_W-1:0] {
    OP_INS_POS = 3'd0,
    OP_REM_POS = 3'd1,
    OP_RD_POS  = 3'd2,
    OP_INS_END = 3'd3,
    OP_REM_END = 3'd4,
    OP_RD_END  = 3'd5
  } op_t;

  typedef enum logic [ST_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_RANGE = 2'd3
  } status_t;

  // Decoded command, broadcast along the cell row.
  typedef struct packed {
    logic              ins;
    logic              rem;
    logic              rd;
    logic [CNT_W-1:0]  pos;
    logic [DATA_W-1:0] value;
    status_t           status;
    logic [CNT_W-1:0]  count_next;
    logic              full_next;
  } pal_cmd_t;

endpackage
`default_nettype wire

// ===== src/pal_cell.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pal_cell: one entry of the list
// Holds one element. On insert it takes its lower neighbour's element (above
// the insert point) or the new value (at it); on remove it takes its upper
// neighbour's element. It also drives its element onto the read bus when hit.
// ----------------------------------------------------------------------------
module pal_cell
  import pal_pkg::*;
(
  input  wire logic              clk,
  input  wire logic [IDX_W-1:0]  idx,
  input  wire pal_cmd_t          cmd,
  input  wire logic              cmd_en,
  input  wire logic [DATA_W-1:0] lower,
  input  wire logic [DATA_W-1:0] upper,
  output logic [DATA_W-1:0]      data,
  output logic [DATA_W-1:0]      rd_data
);

  logic [CNT_W-1:0] my_idx;
  logic             above;
  logic             at;

  assign my_idx  = {{(CNT_W-IDX_W){1'b0}}, idx};
  assign above   = my_idx > cmd.pos;
  assign at      = my_idx == cmd.pos;
  assign rd_data = (cmd.rd && at) ? data : '0;

  always_ff @(posedge clk) begin
    if (cmd_en && cmd.ins && above) begin
      data <= lower;
    end else if (cmd_en && cmd.ins && at) begin
      data <= cmd.value;
    end else if (cmd_en && cmd.rem && (above || at)) begin
      data <= upper;
    end
  end

endmodule
`default_nettype wire

// ===== src/pal_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pal_ctrl: list controller
// Holds the entry count and the capacity register, checks each operation
// against them and decodes it into a command for the cell row.
// ----------------------------------------------------------------------------
module pal_ctrl
  import pal_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              accept,
  input  wire logic [OP_W-1:0]   op,
  input  wire logic [CNT_W-1:0]  position,
  input  wire logic [DATA_W-1:0] value,
  input  wire logic              capacity_we,
  input  wire logic [CNT_W-1:0]  capacity_wdata,
  output pal_cmd_t               cmd,
  output logic [CNT_W-1:0]       cnt
);

  logic [CNT_W-1:0] capacity;
  logic [CNT_W-1:0] lim;
  logic             full;
  logic             empty;
  logic [CNT_W-1:0] last;

  assign lim   = (capacity > CNT_W'(DEPTH)) ? CNT_W'(DEPTH) : capacity;
  assign full  = cnt >= lim;
  assign empty = cnt == '0;
  assign last  = cnt - CNT_W'(1);

  always_comb begin
    cmd        = '0;
    cmd.value  = value;
    cmd.pos    = position;
    cmd.status = ST_OK;
    case (op)
      OP_INS_POS, OP_INS_END: begin
        if (op == OP_INS_END) begin
          cmd.pos = cnt;
        end
        if (full) begin
          cmd.status = ST_FULL;
        end else if (cmd.pos > cnt) begin
          cmd.status = ST_RANGE;
        end else begin
          cmd.ins = 1'b1;
        end
      end
      OP_REM_POS, OP_REM_END, OP_RD_POS, OP_RD_END: begin
        if (op == OP_REM_END || op == OP_RD_END) begin
          cmd.pos = last;
        end
        if (empty) begin
          cmd.status = ST_EMPTY;
        end else if (cmd.pos >= cnt) begin
          cmd.status = ST_RANGE;
        end else if (op == OP_REM_POS || op == OP_REM_END) begin
          cmd.rem = 1'b1;
        end else begin
          cmd.rd = 1'b1;
        end
      end
      default: begin
      end
    endcase
    if (cmd.ins) begin
      cmd.count_next = cnt + CNT_W'(1);
    end else if (cmd.rem) begin
      cmd.count_next = last;
    end else begin
      cmd.count_next = cnt;
    end
    cmd.full_next = cmd.count_next == lim;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CNT_W'(DEPTH);
      cnt      <= '0;
    end else if (capacity_we) begin
      capacity <= capacity_wdata;
      cnt      <= '0;
    end else if (accept) begin
      cnt <= cmd.count_next;
    end
  end

endmodule
`default_nettype wire

// ===== src/positional_array_list_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// positional_array_list_unit: bounded ordered list of signed 32-bit values
// Insert, remove and read at a position or at the end, with status report.
// ----------------------------------------------------------------------------
// One operation is taken per clock cycle and busy stays low: every entry sits
// in its own cell, so an insert or remove moves all later entries in the same
// cycle and a read selects its cell through an AND-OR bus. The result beat
// appears on the strobe done in the cycle after start and must be taken
// then, as the block cannot be stalled. A following operation sees the list as
// the previous one left it. Writing capacity empties the list at once.
module positional_array_list_unit
  import pal_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     start,
  output logic                          busy,
  input  wire logic [OP_W-1:0]          op,
  input  wire logic [CNT_W-1:0]         position,
  input  wire logic signed [DATA_W-1:0] value,
  input  wire logic                     capacity_we,
  input  wire logic [CNT_W-1:0]         capacity_wdata,
  output logic                          done,
  output logic [ST_W-1:0]               status,
  output logic signed [DATA_W-1:0]      read_value,
  output logic [CNT_W-1:0]              count,
  output logic                          is_empty,
  output logic                          is_full
);

  pal_cmd_t          cmd;
  logic              accept;
  logic [CNT_W-1:0]  cnt;
  logic [DATA_W-1:0] cell_data [DEPTH];
  logic [DATA_W-1:0] cell_rd   [DEPTH];
  logic [DATA_W-1:0] rd_bus;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  pal_ctrl u_ctrl (
    .clk            (clk),
    .rst            (rst),
    .accept         (accept),
    .op             (op),
    .position       (position),
    .value          (value),
    .capacity_we    (capacity_we),
    .capacity_wdata (capacity_wdata),
    .cmd            (cmd),
    .cnt            (cnt)
  );

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [DATA_W-1:0] lower;
    logic [DATA_W-1:0] upper;
    if (i == 0) begin : g_lo
      assign lower = '0;
    end else begin : g_lo
      assign lower = cell_data[i-1];
    end
    if (i == DEPTH-1) begin : g_hi
      assign upper = '0;
    end else begin : g_hi
      assign upper = cell_data[i+1];
    end
    pal_cell u_cell (
      .clk     (clk),
      .idx     (IDX_W'(i)),
      .cmd     (cmd),
      .cmd_en  (accept),
      .lower   (lower),
      .upper   (upper),
      .data    (cell_data[i]),
      .rd_data (cell_rd[i])
    );
  end

  // Only the addressed cell drives a non-zero word onto the read bus.
  always_comb begin
    rd_bus = '0;
    for (int i = 0; i < DEPTH; i++) begin
      rd_bus = rd_bus | cell_rd[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      status     <= cmd.status;
      read_value <= cmd.rd ? rd_bus : '1;
      count      <= cmd.count_next;
      is_empty   <= cmd.count_next == '0;
      is_full    <= cmd.full_next;
    end
  end

  a_beat_follows: assert property (@(posedge clk) disable iff (rst)
    accept |=> done) else $error("result beat missing after accepted operation");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    done |-> count <= CNT_W'(DEPTH)) else $error("count above store depth");

  a_error_keeps: assert property (@(posedge clk) disable iff (rst)
    accept && cmd.status != ST_OK |=> done && count == $past(cnt))
    else $error("failed operation changed the count");

  a_empty_flag: assert property (@(posedge clk) disable iff (rst)
    done |-> is_empty == (count == '0)) else $error("empty flag disagrees with count");

  a_count_tracks: assert property (@(posedge clk) disable iff (rst)
    done && !$past(capacity_we) |-> cnt == count)
    else $error("held count differs from reported count");

endmodule
`default_nettype wire

// ===== bench/positional_array_list_unit_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// positional_array_list_unit_test: self-checking bench of the list unit
// Opens with a table of hand-picked operations on an empty list, then runs
// phases of random operations under several capacities, zero and saturated
// among them. The bench keeps its own model of the list, predicts the result
// beat of every accepted operation and compares it field by field.
// ----------------------------------------------------------------------------
module positional_array_list_unit_test
  import pal_pkg::*;
;

  // Codes outside the operation set; the block must leave the list alone.
  localparam logic [OP_W-1:0]   OP_RSVD_LO = 3'd6;
  localparam logic [OP_W-1:0]   OP_RSVD_HI = 3'd7;
  localparam logic [DATA_W-1:0] NO_VALUE   = '1;

  typedef struct packed {
    status_t           status;
    logic [DATA_W-1:0] rd;
    logic [CNT_W-1:0]  cnt;
    logic              empty;
    logic              full;
  } outcome_t;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [CNT_W-1:0]  pos;
    logic [DATA_W-1:0] val;
    logic              pinned;
    outcome_t          want;
  } step_t;

  localparam outcome_t EMPTY_LIST = '{ST_EMPTY, NO_VALUE, 7'd0, 1'b1, 1'b0};
  localparam outcome_t RANGE_FOUR = '{ST_RANGE, NO_VALUE, 7'd4, 1'b0, 1'b0};
  localparam outcome_t FREE       = '{ST_OK, NO_VALUE, 7'd0, 1'b0, 1'b0};

  logic                     clk = 1'b0;
  logic                     rst;
  logic                     start;
  logic                     busy;
  logic [OP_W-1:0]          op;
  logic [CNT_W-1:0]         position;
  logic signed [DATA_W-1:0] value;
  logic                     capacity_we;
  logic [CNT_W-1:0]         capacity_wdata;
  logic                     done;
  logic [ST_W-1:0]          status;
  logic signed [DATA_W-1:0] read_value;
  logic [CNT_W-1:0]         count;
  logic                     is_empty;
  logic                     is_full;

  // Model of the list as the block should hold it after each accepted beat.
  logic [DATA_W-1:0] list_mem [DEPTH];
  int                list_fill;
  int                list_cap;

  outcome_t          pending_results [$];
  int                mismatches;
  step_t             steps [25];

  positional_array_list_unit uut (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .op             (op),
    .position       (position),
    .value          (value),
    .capacity_we    (capacity_we),
    .capacity_wdata (capacity_wdata),
    .done           (done),
    .status         (status),
    .read_value     (read_value),
    .count          (count),
    .is_empty       (is_empty),
    .is_full        (is_full)
  );

  always #4 clk = ~clk;

  function automatic outcome_t list_apply(input logic [OP_W-1:0] code,
                                          input logic [CNT_W-1:0] at,
                                          input logic [DATA_W-1:0] v);
    outcome_t r;
    int       lim;
    int       p;
    bit       full_now;
    bit       empty_now;
    lim       = (list_cap > DEPTH) ? DEPTH : list_cap;
    full_now  = list_fill >= lim;
    empty_now = list_fill == 0;
    r.status  = ST_OK;
    r.rd      = NO_VALUE;
    p         = int'(at);
    case (code)
      OP_INS_POS, OP_INS_END: begin
        if (code == OP_INS_END) p = list_fill;
        // Fullness wins over a bad position.
        if (full_now) r.status = ST_FULL;
        else if (p > list_fill) r.status = ST_RANGE;
        else begin
          for (int i = list_fill; i > p; i--) list_mem[i] = list_mem[i-1];
          list_mem[p] = v;
          list_fill++;
        end
      end
      OP_REM_POS, OP_REM_END: begin
        if (empty_now) r.status = ST_EMPTY;
        else begin
          if (code == OP_REM_END) p = list_fill - 1;
          if (p >= list_fill) r.status = ST_RANGE;
          else begin
            for (int i = p; i + 1 < list_fill; i++) list_mem[i] = list_mem[i+1];
            list_fill--;
          end
        end
      end
      OP_RD_POS, OP_RD_END: begin
        if (empty_now) r.status = ST_EMPTY;
        else begin
          if (code == OP_RD_END) p = list_fill - 1;
          if (p >= list_fill) r.status = ST_RANGE;
          else r.rd = list_mem[p];
        end
      end
      default: ;
    endcase
    r.cnt   = CNT_W'(list_fill);
    r.empty = list_fill == 0;
    r.full  = list_fill == lim;
    return r;
  endfunction

  // Presents one operation and holds it until the block takes the beat.
  task automatic send(input logic [OP_W-1:0] c, input logic [CNT_W-1:0] at,
                      input logic [DATA_W-1:0] v, input logic pinned,
                      input outcome_t want);
    outcome_t model;
    start    <= 1'b1;
    op       <= c;
    position <= at;
    value    <= v;
    forever begin
      @(posedge clk);
      if (!busy) break;
    end
    model = list_apply(c, at, v);
    pending_results.push_back(pinned ? want : model);
  endtask

  task automatic pause(input bit burst);
    int gap;
    gap = burst ? 0 : ($urandom_range(0, 1) ? 0 : $urandom_range(0, 15));
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic set_capacity(input logic [CNT_W-1:0] cap);
    start <= 1'b0;
    forever begin
      @(posedge clk);
      if (pending_results.size() == 0) break;
    end
    capacity_we    <= 1'b1;
    capacity_wdata <= cap;
    @(posedge clk);
    list_cap  = int'(cap);
    list_fill = 0;
    capacity_we <= 1'b0;
  endtask

  // Mostly well-formed positions around the current fill, with some just past
  // the end and some anywhere in the field.
  task automatic random_item(input int ins_pct);
    int                r;
    int                hi;
    logic [OP_W-1:0]   c;
    logic [CNT_W-1:0]  at;
    logic [DATA_W-1:0] v;
    r = $urandom_range(0, 99);
    if (r < ins_pct) c = $urandom_range(0, 1) ? OP_INS_POS : OP_INS_END;
    else if (r >= 97) c = $urandom_range(0, 1) ? OP_RSVD_LO : OP_RSVD_HI;
    else begin
      case ($urandom_range(0, 3))
        0:       c = OP_REM_POS;
        1:       c = OP_REM_END;
        2:       c = OP_RD_POS;
        default: c = OP_RD_END;
      endcase
    end
    hi = (c == OP_INS_POS) ? list_fill : list_fill - 1;
    if (hi < 0) hi = 0;
    r = $urandom_range(0, 9);
    if (r < 8) at = CNT_W'($urandom_range(0, hi));
    else if (r == 8) at = CNT_W'(hi + 1);
    else at = CNT_W'($urandom_range(0, 127));
    v = $urandom;
    r = $urandom_range(0, 15);
    if (r == 0) v = 32'h7fff_ffff;
    else if (r == 1) v = 32'h8000_0000;
    send(c, at, v, 1'b0, FREE);
  endtask

  task automatic run_phase(input logic [CNT_W-1:0] cap, input int ins_pct,
                           input int n, input bit burst);
    set_capacity(cap);
    repeat (n) begin
      random_item(ins_pct);
      pause(burst);
    end
  endtask

  task automatic compare(input string field, input logic [DATA_W-1:0] want,
                         input logic [DATA_W-1:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t: %s expected %h got %h", $time, field, want, got);
    end
  endtask

  always @(posedge clk) begin : check_results
    outcome_t want;
    if (!rst && done) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        $display("%0t: result beat with nothing expected", $time);
      end else begin
        want = pending_results.pop_front();
        compare("status", want.status, status);
        compare("read_value", want.rd, read_value);
        compare("count", want.cnt, count);
        compare("is_empty", want.empty, is_empty);
        compare("is_full", want.full, is_full);
      end
    end
  end

  initial begin
    #5_000_000;
    $display("positional_array_list_unit verification failed");
    $finish;
  end

  initial begin
    rst            = 1'b1;
    start          = 1'b0;
    op             = '0;
    position       = '0;
    value          = '0;
    capacity_we    = 1'b0;
    capacity_wdata = '0;
    mismatches     = 0;
    list_fill      = 0;
    list_cap       = 64;
    foreach (list_mem[i]) list_mem[i] = '0;

    // Capacity is at its reset value of 64 throughout the table.
    steps = '{
      '{OP_RD_POS,  7'd0,   32'd0,         1'b1, EMPTY_LIST},
      '{OP_REM_POS, 7'd0,   32'd0,         1'b1, EMPTY_LIST},
      '{OP_REM_END, 7'd0,   32'd0,         1'b1, EMPTY_LIST},
      '{OP_RD_END,  7'd0,   32'd0,         1'b1, EMPTY_LIST},
      '{OP_INS_POS, 7'd1,   32'd5,         1'b1,
        '{ST_RANGE, NO_VALUE, 7'd0, 1'b1, 1'b0}},
      '{OP_INS_POS, 7'd0,   32'h7fff_ffff, 1'b1,
        '{ST_OK, NO_VALUE, 7'd1, 1'b0, 1'b0}},
      '{OP_INS_END, 7'd0,   32'h8000_0000, 1'b1,
        '{ST_OK, NO_VALUE, 7'd2, 1'b0, 1'b0}},
      '{OP_INS_POS, 7'd1,   32'hffff_ffff, 1'b0, FREE},
      '{OP_INS_POS, 7'd3,   32'd0,         1'b0, FREE},
      '{OP_INS_POS, 7'd127, 32'h1234_5678, 1'b1, RANGE_FOUR},
      '{OP_RD_POS,  7'd0,   32'd0,         1'b0, FREE},
      '{OP_RD_POS,  7'd3,   32'd0,         1'b0, FREE},
      '{OP_RD_POS,  7'd4,   32'd0,         1'b1, RANGE_FOUR},
      '{OP_RD_POS,  7'd127, 32'd0,         1'b1, RANGE_FOUR},
      '{OP_RD_END,  7'd0,   32'd0,         1'b0, FREE},
      '{OP_REM_POS, 7'd4,   32'd0,         1'b1, RANGE_FOUR},
      '{OP_REM_POS, 7'd127, 32'd0,         1'b1, RANGE_FOUR},
      '{OP_REM_POS, 7'd1,   32'd0,         1'b0, FREE},
      '{OP_RSVD_LO, 7'd0,   32'd0,         1'b1,
        '{ST_OK, NO_VALUE, 7'd3, 1'b0, 1'b0}},
      '{OP_RSVD_HI, 7'd127, 32'hffff_ffff, 1'b1,
        '{ST_OK, NO_VALUE, 7'd3, 1'b0, 1'b0}},
      '{OP_REM_END, 7'd0,   32'd0,         1'b0, FREE},
      '{OP_REM_POS, 7'd0,   32'd0,         1'b0, FREE},
      '{OP_RD_END,  7'd0,   32'd0,         1'b0, FREE},
      '{OP_REM_END, 7'd0,   32'd0,         1'b1,
        '{ST_OK, NO_VALUE, 7'd0, 1'b1, 1'b0}},
      '{OP_RD_POS,  7'd0,   32'd0,         1'b1, EMPTY_LIST}
    };

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (steps[i]) begin
      send(steps[i].op, steps[i].pos, steps[i].val, steps[i].pinned, steps[i].want);
      pause(i >= 12);
    end

    // Capacity zero makes the list full and empty at once; 127 and 65 must
    // saturate to the depth of the store.
    run_phase(7'd0,   50,  40, 1'b0);
    run_phase(7'd1,   50, 100, 1'b1);
    run_phase(7'd127, 70, 300, 1'b0);
    run_phase(7'd64,  55, 300, 1'b1);
    run_phase(7'd65,  65, 200, 1'b0);
    run_phase(7'd3,   50, 200, 1'b0);
    for (int k = 0; k < 3; k++) begin
      run_phase(CNT_W'($urandom_range(2, 10)), 55, 150, k[0]);
    end
    run_phase(7'd64,  60, 300, 1'b1);

    start <= 1'b0;
    for (int k = 0; k < 200 && pending_results.size() != 0; k++) @(posedge clk);
    if (pending_results.size() != 0) begin
      mismatches++;
      $display("%0t: %0d results never arrived", $time, pending_results.size());
    end
    repeat (4) @(posedge clk);
    if (mismatches == 0) begin
      $display("positional_array_list_unit verification clean");
    end else begin
      $display("positional_array_list_unit verification failed");
    end
    $finish;
  end

endmodule
